@@ hw/rtl/bole_pkg.sv @@
// Shared types and constants for the bounded ordered list engine.
// No dependencies; used by bole_cell and bounded_ordered_list_engine.
`default_nettype none

package bole_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned CntW       = 5;
  localparam int unsigned StoreDepth = 16;
  localparam int unsigned CmdW       = 3;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned InTdataW   = 72;  // 67 payload bits padded to bytes
  localparam int unsigned OutTdataW  = 40;
  localparam int unsigned CapacityDef = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_KEY   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_LIST      = 3'd5
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STAT_DONE  = 3'd0,
    STAT_EMPTY = 3'd1,
    STAT_NOKEY = 3'd2,
    STAT_FULL  = 3'd3,
    STAT_ELEM  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CELL_IDLE,
    CELL_MATCH,
    CELL_INSERT,
    CELL_SHIFT_LEFT,
    CELL_ROTATE
  } cell_op_e;

  typedef enum logic [1:0] {
    INS_NONE,
    INS_FRONT,
    INS_BACK,
    INS_KEY
  } ins_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EDIT,
    ST_LIST
  } state_e;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cell_op_e         op;
    ins_mode_e        mode;
    logic [CntW-1:0]  occ;
    logic [DataW-1:0] value;
    logic [DataW-1:0] key;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/bole_cell.sv @@
// One list cell: holds one entry, compares it to the key and trades words
// with its neighbors. Depends on bole_pkg.
`default_nettype none

module bole_cell #(
  parameter int unsigned Idx = 0
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire bole_pkg::cell_ctrl_t      ctrl_i,
  input  wire logic [bole_pkg::DataW-1:0] left_i,
  input  wire logic [bole_pkg::DataW-1:0] right_i,
  input  wire logic [bole_pkg::DataW-1:0] head_i,
  input  wire logic                      seen_i,
  output logic      [bole_pkg::DataW-1:0] val_o,
  output logic                           seen_o
);
  import bole_pkg::*;

  localparam logic [CntW-1:0] IdxC = CntW'(Idx);

  logic [DataW-1:0] val_q, val_d;
  logic             match_q, match_d;
  logic             here;

  // insert point of this cell
  always_comb begin
    case (ctrl_i.mode)
      INS_FRONT: here = (IdxC == '0);
      INS_BACK:  here = (IdxC == ctrl_i.occ);
      INS_KEY:   here = match_q;
      default:   here = 1'b0;
    endcase
  end

  assign seen_o = seen_i | here;
  assign val_o  = val_q;

  always_comb begin
    val_d   = val_q;
    match_d = match_q;
    case (ctrl_i.op)
      CELL_MATCH: match_d = (IdxC < ctrl_i.occ) && (val_q == ctrl_i.key);
      CELL_INSERT: begin
        if (seen_i) begin
          val_d = left_i;
        end else if (here) begin
          val_d = ctrl_i.value;
        end
      end
      CELL_SHIFT_LEFT: val_d = right_i;
      CELL_ROTATE: begin
        // live entries move one toward the front; the head wraps to the tail
        if ((IdxC + 1'b1) < ctrl_i.occ) begin
          val_d = right_i;
        end else if ((IdxC + 1'b1) == ctrl_i.occ) begin
          val_d = head_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

@@ hw/rtl/bounded_ordered_list_engine.sv @@
// Top level of the bounded ordered list engine: controller, result register
// and the row of bole_cell entries. Depends on bole_pkg and bole_cell.
`default_nettype none

// The engine keeps an ordered list of up to min(CAPACITY, 16) signed 32-bit
// words in a row of cells, front at cell 0. One command is taken at a time.
// Insert front, insert back, delete front and delete back go from accept to
// an edit state in which the cells move in parallel (delete back only lowers
// the count). Insert before key first passes a search state where every cell
// compares its word against the key and registers a match flag; the first
// match is then found by a ripple through the row. Listing N held words
// rotates the row one place per cycle while the result register is free, and
// cell 0 is emitted each time; after N steps the original order is restored.
// The next command is accepted once the last result is in the output
// register. Results with stall on the master side simply hold the
// controller. Words never written are never read, so cell words need no reset.
module bounded_ordered_list_engine #(
  parameter int unsigned CAPACITY = bole_pkg::CapacityDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // command word
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [2:0] command, [34:3] value, [66:35] key, [71:67] zero
  input  wire logic [bole_pkg::InTdataW-1:0] s_axis_tdata_i,
  // result word
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [2:0] status, [34:3] element, [39:35] count
  output logic      [bole_pkg::OutTdataW-1:0] m_axis_tdata_o,
  output logic                               m_axis_tlast_o
);
  import bole_pkg::*;

  localparam int unsigned Held = (CAPACITY < StoreDepth) ? CAPACITY : StoreDepth;
  localparam logic [CntW-1:0] HeldC = CntW'(Held);

  state_e state_q, state_d;

  cmd_e             cmd_q;
  logic [DataW-1:0] value_q, key_q;
  logic [CntW-1:0]  occ_q, occ_d;
  logic [CntW-1:0]  list_q, list_d;

  logic                 out_valid_q;
  logic [OutTdataW-1:0] out_data_q;
  logic                 out_last_q;

  logic             slot_free, accept, full, empty, found, list_last;
  logic             res_load, res_last;
  status_e          res_status;
  logic [DataW-1:0] res_elem;
  cell_ctrl_t       ctrl;
  cell_op_e         cell_op;
  ins_mode_e        mode;

  logic [DataW-1:0] val   [Held];
  logic             seen  [Held+1];

  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign full      = (occ_q >= HeldC);
  assign empty     = (occ_q == '0);
  assign found     = seen[Held];
  assign list_last = ((list_q + 1'b1) == occ_q);

  // ---------------------------------------------------------------------
  // Cell row
  // ---------------------------------------------------------------------
  always_comb begin
    case (cmd_q)
      CMD_INS_FRONT: mode = INS_FRONT;
      CMD_INS_BACK:  mode = INS_BACK;
      CMD_INS_KEY:   mode = INS_KEY;
      default:       mode = INS_NONE;
    endcase
  end

  assign ctrl.op    = cell_op;
  assign ctrl.mode  = mode;
  assign ctrl.occ   = occ_q;
  assign ctrl.value = value_q;
  assign ctrl.key   = key_q;

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < Held; i++) begin : g_cell
    logic [DataW-1:0] left_w, right_w;
    // the ends see themselves; only shift left selects one, in the last cell
    if (i == 0) begin : g_first
      assign left_w = val[i];
    end else begin : g_mid_l
      assign left_w = val[i-1];
    end
    if (i == Held - 1) begin : g_last
      assign right_w = val[i];
    end else begin : g_mid_r
      assign right_w = val[i+1];
    end

    bole_cell #(
      .Idx(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .left_i (left_w),
      .right_i(right_w),
      .head_i (val[0]),
      .seen_i (seen[i]),
      .val_o  (val[i]),
      .seen_o (seen[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Controller: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          case (s_axis_tdata_i[CmdW-1:0])
            CMD_INS_KEY: state_d = ST_SEARCH;
            CMD_INS_FRONT, CMD_INS_BACK, CMD_DEL_FRONT, CMD_DEL_BACK,
            CMD_LIST: state_d = ST_EDIT;
            default: state_d = ST_IDLE;  // unused codes are dropped
          endcase
        end
      end
      ST_SEARCH: state_d = ST_EDIT;
      ST_EDIT: begin
        if (slot_free) begin
          state_d = (cmd_q == CMD_LIST && !empty) ? ST_LIST : ST_IDLE;
        end
      end
      ST_LIST: begin
        if (slot_free && list_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Controller: outputs
  // ---------------------------------------------------------------------
  always_comb begin
    s_axis_tready_o = 1'b0;
    cell_op         = CELL_IDLE;
    occ_d           = occ_q;
    list_d          = list_q;
    res_load        = 1'b0;
    res_status      = STAT_DONE;
    res_elem        = '0;
    res_last        = 1'b1;
    case (state_q)
      ST_IDLE:   s_axis_tready_o = 1'b1;
      ST_SEARCH: cell_op = CELL_MATCH;
      ST_EDIT: begin
        if (slot_free) begin
          res_load = 1'b1;
          case (cmd_q)
            CMD_INS_FRONT, CMD_INS_BACK: begin
              if (full) begin
                res_status = STAT_FULL;
              end else begin
                cell_op = CELL_INSERT;
                occ_d   = occ_q + 1'b1;
              end
            end
            CMD_INS_KEY: begin
              // empty beats not-found beats full
              if (empty) begin
                res_status = STAT_EMPTY;
              end else if (!found) begin
                res_status = STAT_NOKEY;
              end else if (full) begin
                res_status = STAT_FULL;
              end else begin
                cell_op = CELL_INSERT;
                occ_d   = occ_q + 1'b1;
              end
            end
            CMD_DEL_FRONT: begin
              if (empty) begin
                res_status = STAT_EMPTY;
              end else begin
                cell_op = CELL_SHIFT_LEFT;
                occ_d   = occ_q - 1'b1;
              end
            end
            CMD_DEL_BACK: begin
              if (empty) begin
                res_status = STAT_EMPTY;
              end else begin
                occ_d = occ_q - 1'b1;
              end
            end
            CMD_LIST: begin
              if (empty) begin
                res_status = STAT_EMPTY;
              end else begin
                res_load = 1'b0;
                list_d   = '0;
              end
            end
            default: res_load = 1'b0;
          endcase
        end
      end
      ST_LIST: begin
        if (slot_free) begin
          res_load   = 1'b1;
          res_status = STAT_ELEM;
          res_elem   = val[0];
          res_last   = list_last;
          cell_op    = CELL_ROTATE;
          list_d     = list_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      list_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      list_q  <= list_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // command and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(s_axis_tdata_i[CmdW-1:0]);
      value_q <= s_axis_tdata_i[CmdW +: DataW];
      key_q   <= s_axis_tdata_i[CmdW+DataW +: DataW];
    end
    if (res_load) begin
      out_data_q <= {occ_d, res_elem, res_status};
      out_last_q <= res_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

@@ tb/bounded_ordered_list_engine_test.sv @@
// Self-checking bench for bounded_ordered_list_engine: random list edits and
// listings, checked word by word against an in-bench list mirror.
// Depends on bole_pkg and the engine RTL.
`default_nettype none

module bounded_ordered_list_engine_test;
  import bole_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Capacity    = bole_pkg::CapacityDef;
  localparam int unsigned HeldLimit   = (Capacity < StoreDepth) ? Capacity : StoreDepth;
  localparam int unsigned ItemsTarget = 410;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned SettleCycles = 8;  // covers a dropped 6/7 command in flight
  localparam int unsigned HoldCycles  = 90;
  localparam int unsigned QuietTail   = 60;
  localparam int unsigned ReportCap   = 40;

  // One result word, split into its fields.
  typedef struct {
    logic [StatusW-1:0] status;
    logic [DataW-1:0]   element;
    logic [CntW-1:0]    count;
    logic               last;
  } list_result_t;

  // Mirror of the list plus the queue of results still owed by the engine.
  class list_mirror;
    logic [DataW-1:0] words[StoreDepth];
    int unsigned      held = 0;
    int unsigned      errors = 0;
    list_result_t     awaited_results[$];

    function void owe(logic [StatusW-1:0] status, logic [DataW-1:0] element, logic last);
      list_result_t r;
      r.status  = status;
      r.element = element;
      r.count   = CntW'(held);
      r.last    = last;
      awaited_results.push_back(r);
    endfunction

    function void insert_at(int unsigned pos, logic [DataW-1:0] v);
      for (int unsigned i = held; i > pos; i--) words[i] = words[i-1];
      words[pos] = v;
      held++;
    endfunction

    // Called on every accepted command word.
    function void apply_command(logic [CmdW-1:0] cmd, logic [DataW-1:0] value,
                                logic [DataW-1:0] key);
      logic [StatusW-1:0] st;
      int unsigned        i;
      st = STAT_DONE;
      case (cmd)
        CMD_INS_FRONT: begin
          if (held >= HeldLimit) st = STAT_FULL;
          else insert_at(0, value);
        end
        CMD_INS_BACK: begin
          if (held >= HeldLimit) st = STAT_FULL;
          else insert_at(held, value);
        end
        CMD_INS_KEY: begin
          // empty beats not-found beats full
          if (held == 0) begin
            st = STAT_EMPTY;
          end else begin
            i = 0;
            while (i < held && words[i] !== key) i++;
            if (i >= held) st = STAT_NOKEY;
            else if (held >= HeldLimit) st = STAT_FULL;
            else insert_at(i, value);
          end
        end
        CMD_DEL_FRONT: begin
          if (held == 0) begin
            st = STAT_EMPTY;
          end else begin
            for (i = 0; i + 1 < held; i++) words[i] = words[i+1];
            held--;
          end
        end
        CMD_DEL_BACK: begin
          if (held == 0) st = STAT_EMPTY;
          else held--;
        end
        CMD_LIST: begin
          if (held == 0) owe(STAT_EMPTY, '0, 1'b1);
          else for (i = 0; i < held; i++) owe(STAT_ELEM, words[i], i + 1 == held);
          return;
        end
        default: return;  // codes 6 and 7 are dropped silently
      endcase
      owe(st, '0, 1'b1);
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= ReportCap)
          $display("%0t: unexpected word, expected none, actual status=%0d element=%h count=%0d last=%b",
                   $time, got.status, got.element, got.count, got.last);
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status || got.element !== want.element ||
          got.count !== want.count || got.last !== want.last) begin
        errors++;
        if (errors <= ReportCap)
          $display("%0t: mismatch, expected status=%0d element=%h count=%0d last=%b, actual status=%0d element=%h count=%0d last=%b",
                   $time, want.status, want.element, want.count, want.last,
                   got.status, got.element, got.count, got.last);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_ready;
  logic [InTdataW-1:0]  cmd_data = '0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  logic [OutTdataW-1:0] res_data;
  logic                 res_last;

  list_mirror  mirror;
  int unsigned words_sent = 0;
  bit          send_idle_en = 1'b0;
  bit          recv_idle_en = 1'b0;
  int unsigned hold_req = 0;   // long receiver hold, handed to the sink process
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  bounded_ordered_list_engine #(
    .CAPACITY(Capacity)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(cmd_valid),
    .s_axis_tready_o(cmd_ready),
    .s_axis_tdata_i (cmd_data),
    .m_axis_tvalid_o(res_valid),
    .m_axis_tready_i(res_ready),
    .m_axis_tdata_o (res_data),
    .m_axis_tlast_o (res_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Sink: random stall bursts, plus the long hold when one is requested.
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      res_ready <= 1'b0;
    end else if (recv_idle_en && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 6);
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    list_result_t got;
    if (rst_n && res_valid === 1'b1 && res_ready) begin
      got.status  = res_data[2:0];
      got.element = res_data[34:3];
      got.count   = res_data[39:35];
      got.last    = res_last;
      mirror.check_result(got);
    end
  end

  // Watchdog.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("** bounded_ordered_list_engine: FAILED **");
    $finish;
  end

  // Offer one command word and hold it until it is taken.
  task automatic send_cmd(input logic [CmdW-1:0] cmd, input logic [DataW-1:0] value,
                          input logic [DataW-1:0] key);
    int unsigned gap;
    if (send_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      cmd_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd_data  <= {5'b0, key, value, cmd};
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    mirror.apply_command(cmd, value, key);
    if (cmd <= CMD_LIST) words_sent++;
  endtask

  // Stop offering, let every owed result arrive, then settle.
  task automatic wait_drained();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (mirror.awaited_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Extremes and a tiny pool so that duplicate keys show up often.
  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return DataW'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_key();
    if (mirror.held != 0 && $urandom_range(0, 3) != 0)
      return mirror.words[$urandom_range(0, mirror.held - 1)];
    return pick_value();
  endfunction

  task automatic send_weighted(input int unsigned ins_pct, input int unsigned del_pct);
    int unsigned     roll;
    logic [CmdW-1:0] op;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) begin
      case ($urandom_range(0, 3))
        0:       op = CMD_INS_FRONT;
        1:       op = CMD_INS_BACK;
        default: op = CMD_INS_KEY;
      endcase
    end else if (roll < ins_pct + del_pct) begin
      op = $urandom_range(0, 1) ? CMD_DEL_FRONT : CMD_DEL_BACK;
    end else if (roll < 97) begin
      op = CMD_LIST;
    end else begin
      op = CmdW'($urandom_range(6, 7));  // unused codes, must be dropped
    end
    send_cmd(op, pick_value(), pick_key());
  endtask

  // Grow to full, probe the full cases, then list.
  task automatic fill_list();
    while (mirror.held < HeldLimit) send_weighted(100, 0);
    repeat ($urandom_range(2, 4)) send_weighted(100, 0);
    send_cmd(CMD_LIST, $urandom, $urandom);
  endtask

  // Shrink to empty, probe deletes on an empty list, then list.
  task automatic drain_list();
    while (mirror.held != 0) send_weighted(0, 100);
    repeat ($urandom_range(1, 2)) send_weighted(0, 100);
    send_cmd(CMD_LIST, $urandom, $urandom);
  endtask

  task automatic mix_list();
    repeat ($urandom_range(8, 16)) send_weighted(45, 30);
  endtask

  initial begin
    bit hold_done;
    bit pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    mirror = new;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-list cases, dropped codes, extremes, duplicate keys.
    send_cmd(CMD_LIST, 32'h0, 32'h0);
    send_cmd(CMD_DEL_FRONT, 32'h0, 32'h0);
    send_cmd(CMD_DEL_BACK, 32'h0, 32'h0);
    send_cmd(CMD_INS_KEY, 32'h1234_5678, 32'h0);
    send_cmd(CmdW'(6), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(CmdW'(7), 32'h0, 32'h0);
    send_cmd(CMD_INS_BACK, 32'h7FFF_FFFF, 32'h0);
    send_cmd(CMD_DEL_BACK, 32'h0, 32'h0);           // one entry off the back
    send_cmd(CMD_INS_BACK, 32'h7FFF_FFFF, 32'h0);
    send_cmd(CMD_DEL_FRONT, 32'h0, 32'h0);
    send_cmd(CMD_INS_FRONT, 32'h8000_0000, 32'h0);
    send_cmd(CMD_INS_BACK, 32'h0, 32'hFFFF_FFFF);
    send_cmd(CMD_INS_FRONT, 32'hFFFF_FFFF, 32'h0);
    send_cmd(CMD_INS_KEY, 32'h1, 32'h1234_5678);    // key absent
    send_cmd(CMD_INS_KEY, 32'h1, 32'h0);
    send_cmd(CMD_INS_BACK, 32'hFFFF_FFFF, 32'h0);   // second copy of a key
    send_cmd(CMD_INS_KEY, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
    send_cmd(CMD_LIST, 32'h0, 32'h0);
    send_cmd(CMD_DEL_FRONT, 32'h0, 32'h0);
    send_cmd(CMD_DEL_BACK, 32'h0, 32'h0);
    send_cmd(CMD_LIST, 32'h0, 32'h0);
    wait_drained();

    // Random phases with random idling on both sides.
    while (words_sent < ItemsTarget) begin
      if (words_sent + QuietTail > ItemsTarget) begin
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
      end else begin
        send_idle_en = $urandom_range(0, 2) != 0;
        recv_idle_en = $urandom_range(0, 2) != 0;
      end
      if (!hold_done && words_sent >= 120) begin
        // sink holds off while commands keep coming, so the input backs up
        hold_done = 1'b1;
        hold_req  = HoldCycles;
        fill_list();
        mix_list();
      end else if (!pause_done && words_sent >= 240) begin
        pause_done = 1'b1;
        wait_drained();
      end else begin
        case ($urandom_range(0, 3))
          0:       fill_list();
          1:       drain_list();
          default: mix_list();
        endcase
      end
    end

    wait_drained();
    if (mirror.errors == 0 && mirror.awaited_results.size() == 0) begin
      $display("** bounded_ordered_list_engine: PASSED **");
    end else begin
      $display("** bounded_ordered_list_engine: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
